### design/wwtm_pkg.sv
// shared types, codes and helpers for the word wrap text measurer
package wwtm_pkg;

  localparam int unsigned CP_W  = 21;
  localparam int unsigned CNT_W = 16;

  localparam logic [CP_W-1:0]  CODE_END     = 21'd0;
  localparam logic [CP_W-1:0]  CODE_NEWLINE = 21'd10;
  localparam logic [CP_W-1:0]  CODE_SPACE   = 21'd32;
  localparam logic [CNT_W-1:0] MAX16        = 16'hFFFF;
  localparam logic [CNT_W-1:0] LIMIT_RESET  = 16'd32;

  typedef enum logic [1:0] {
    CLS_CHAR,
    CLS_SPACE,
    CLS_NEWLINE,
    CLS_END
  } cls_t;

  function automatic logic [CNT_W-1:0] sat_inc(input logic [CNT_W-1:0] v);
    return (v == MAX16) ? v : v + 16'd1;
  endfunction

  function automatic logic [CNT_W-1:0] max16(input logic [CNT_W-1:0] a,
                                             input logic [CNT_W-1:0] b);
    return (a > b) ? a : b;
  endfunction

  function automatic cls_t classify(input logic [CP_W-1:0] cp);
    cls_t c;
    if (cp == CODE_END) begin
      c = CLS_END;
    end else if (cp == CODE_NEWLINE) begin
      c = CLS_NEWLINE;
    end else if (cp == CODE_SPACE) begin
      c = CLS_SPACE;
    end else begin
      c = CLS_CHAR;
    end
    return c;
  endfunction

endpackage

### design/wwtm_front.sv
// input stage: accepts character beats and classifies them
module wwtm_front (
  input  logic                      clk,
  input  logic                      rst_n,
  input  logic                      in_valid,
  output logic                      in_stall,
  input  logic [wwtm_pkg::CP_W-1:0] in_code_point,
  output logic                      push_vld,
  output wwtm_pkg::cls_t            push_cls,
  input  logic                      q_full
);
  import wwtm_pkg::*;

  logic vld_r;
  cls_t cls_r;
  logic load;

  assign in_stall = vld_r & q_full;
  assign load     = ~in_stall;
  assign push_vld = vld_r;
  assign push_cls = cls_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vld_r <= 1'b0;
    end else if (load) begin
      vld_r <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (load && in_valid) begin
      cls_r <= classify(in_code_point);
    end
  end

endmodule

### design/wwtm_queue.sv
// small fifo of classified beats between front and back
module wwtm_queue #(
  parameter int unsigned DEPTH = 4
) (
  input  logic           clk,
  input  logic           rst_n,
  input  logic           push,
  input  wwtm_pkg::cls_t push_cls,
  output logic           full,
  input  logic           pop,
  output logic           pop_vld,
  output wwtm_pkg::cls_t pop_cls
);
  import wwtm_pkg::*;

  localparam int unsigned AW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int unsigned CW = $clog2(DEPTH + 1);

  cls_t          mem_r [DEPTH];
  logic [AW-1:0] wr_ptr_r, rd_ptr_r;
  logic [CW-1:0] count_r;
  logic          do_push;

  assign full    = (count_r == CW'(DEPTH));
  assign pop_vld = (count_r != '0);
  assign pop_cls = mem_r[rd_ptr_r];
  assign do_push = push & ~full;

  function automatic logic [AW-1:0] ptr_inc(input logic [AW-1:0] p);
    return (p == AW'(DEPTH - 1)) ? '0 : p + AW'(1);
  endfunction

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      count_r  <= '0;
    end else begin
      if (do_push) begin
        wr_ptr_r <= ptr_inc(wr_ptr_r);
      end
      if (pop) begin
        rd_ptr_r <= ptr_inc(rd_ptr_r);
      end
      case ({do_push, pop})
        2'b10:   count_r <= count_r + CW'(1);
        2'b01:   count_r <= count_r - CW'(1);
        default: count_r <= count_r;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (do_push) begin
      mem_r[wr_ptr_r] <= push_cls;
    end
  end

endmodule

### design/wwtm_back.sv
// wrap state update and registered result beat
module wwtm_back (
  input  logic                       clk,
  input  logic                       rst_n,
  input  logic [wwtm_pkg::CNT_W-1:0] line_limit,
  input  logic                       q_vld,
  input  wwtm_pkg::cls_t             q_cls,
  output logic                       q_pop,
  output logic                       out_valid,
  input  logic                       out_stall,
  output logic                       out_fits,
  output logic [wwtm_pkg::CNT_W-1:0] out_width_chars,
  output logic [wwtm_pkg::CNT_W-1:0] out_row_count,
  output logic [wwtm_pkg::CNT_W-1:0] out_char_count
);
  import wwtm_pkg::*;

  logic [CNT_W-1:0] line_len_r, line_len_nxt;
  logic [CNT_W-1:0] longest_r, longest_nxt;
  logic             seen_r, seen_nxt;
  logic [CNT_W-1:0] pos_r, pos_nxt;
  logic [CNT_W-1:0] row_r, row_nxt;
  logic [CNT_W-1:0] total_r, total_nxt;
  logic             ovf_r, ovf_nxt;
  logic             out_vld_r, out_vld_nxt;
  logic             fits_r;
  logic [CNT_W-1:0] width_r, rows_r, chars_r;
  logic             is_end, out_free, emit, ok;
  logic             place, skip_sp, at_limit;

  assign is_end   = (q_cls == CLS_END);
  assign out_free = ~out_vld_r | ~out_stall;
  assign q_pop    = q_vld & (~is_end | out_free);
  assign emit     = q_pop & is_end;
  assign ok       = ~ovf_r & (line_limit != '0);
  assign at_limit = (line_limit == '0) ||
                    ({1'b0, line_len_r} + 17'd1 >= {1'b0, line_limit});
  assign skip_sp  = (seen_r && pos_r == line_len_r) || (line_len_r == '0);

  always_comb begin
    line_len_nxt = line_len_r;
    longest_nxt  = longest_r;
    seen_nxt     = seen_r;
    pos_nxt      = pos_r;
    row_nxt      = row_r;
    total_nxt    = total_r;
    ovf_nxt      = ovf_r;
    place        = 1'b0;
    if (q_pop) begin
      if (is_end) begin
        line_len_nxt = '0;
        longest_nxt  = '0;
        seen_nxt     = 1'b0;
        pos_nxt      = '0;
        row_nxt      = '0;
        total_nxt    = '0;
        ovf_nxt      = 1'b0;
      end else begin
        total_nxt = sat_inc(total_r);
        if (!ovf_r) begin
          case (q_cls)
            CLS_NEWLINE: begin
              longest_nxt  = max16(longest_r, line_len_r);
              row_nxt      = sat_inc(row_r);
              line_len_nxt = '0;
              seen_nxt     = 1'b0;
            end
            CLS_SPACE: begin
              if (!skip_sp) begin
                pos_nxt  = line_len_r;
                seen_nxt = 1'b1;
                place    = 1'b1;
              end
            end
            default: place = 1'b1;
          endcase
        end
      end
    end
    if (place) begin
      if (at_limit) begin
        if (!seen_nxt) begin
          ovf_nxt = 1'b1;
        end else begin
          longest_nxt  = max16(longest_r, pos_nxt);
          row_nxt      = sat_inc(row_r);
          line_len_nxt = (line_len_r >= pos_nxt) ? line_len_r - pos_nxt : '0;
          seen_nxt     = 1'b0;
        end
      end else begin
        line_len_nxt = line_len_r + 16'd1;
      end
    end
  end

  always_comb begin
    if (emit) begin
      out_vld_nxt = 1'b1;
    end else if (!out_stall) begin
      out_vld_nxt = 1'b0;
    end else begin
      out_vld_nxt = out_vld_r;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      line_len_r <= '0;
      longest_r  <= '0;
      seen_r     <= 1'b0;
      pos_r      <= '0;
      row_r      <= '0;
      total_r    <= '0;
      ovf_r      <= 1'b0;
      out_vld_r  <= 1'b0;
    end else begin
      line_len_r <= line_len_nxt;
      longest_r  <= longest_nxt;
      seen_r     <= seen_nxt;
      pos_r      <= pos_nxt;
      row_r      <= row_nxt;
      total_r    <= total_nxt;
      ovf_r      <= ovf_nxt;
      out_vld_r  <= out_vld_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (emit) begin
      fits_r  <= ok;
      width_r <= ok ? max16(longest_r, line_len_r) : '0;
      rows_r  <= ok ? sat_inc(row_r) : '0;
      chars_r <= total_r;
    end
  end

  assign out_valid       = out_vld_r;
  assign out_fits        = fits_r;
  assign out_width_chars = width_r;
  assign out_row_count   = rows_r;
  assign out_char_count  = chars_r;

endmodule

### design/word_wrap_text_measurer.sv
// top level of the greedy word wrap text measurer
// Takes one character beat per cycle unless in_stall is high and, on code 0, returns one
// result beat with the fits flag, widest line, row count and character count of the
// greedy-wrapped text. Sustained rate is one beat per cycle while nothing stalls; a
// character passes the classifier register, the beat queue and the state update, and a
// terminator's result is held in the result register. The queue lets the input keep
// flowing while a result waits to be taken; only terminators wait on the result register.
// line_limit must be written while no text is in flight.
module word_wrap_text_measurer #(
  parameter int unsigned QUEUE_DEPTH = 4
) (
  input  logic                       clk,
  input  logic                       rst_n,
  input  logic                       cfg_we,
  input  logic [wwtm_pkg::CNT_W-1:0] cfg_wdata,
  input  logic                       in_valid,
  output logic                       in_stall,
  input  logic [wwtm_pkg::CP_W-1:0]  in_code_point,
  output logic                       out_valid,
  input  logic                       out_stall,
  output logic                       out_fits,
  output logic [wwtm_pkg::CNT_W-1:0] out_width_chars,
  output logic [wwtm_pkg::CNT_W-1:0] out_row_count,
  output logic [wwtm_pkg::CNT_W-1:0] out_char_count
);
  import wwtm_pkg::*;

  logic [CNT_W-1:0] line_limit_r;
  logic             push_vld, q_full, q_pop, q_vld;
  cls_t             push_cls, q_cls;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      line_limit_r <= LIMIT_RESET;
    end else if (cfg_we) begin
      line_limit_r <= cfg_wdata;
    end
  end

  wwtm_front u_front (
    .clk           (clk),
    .rst_n         (rst_n),
    .in_valid      (in_valid),
    .in_stall      (in_stall),
    .in_code_point (in_code_point),
    .push_vld      (push_vld),
    .push_cls      (push_cls),
    .q_full        (q_full)
  );

  wwtm_queue #(
    .DEPTH (QUEUE_DEPTH)
  ) u_queue (
    .clk      (clk),
    .rst_n    (rst_n),
    .push     (push_vld),
    .push_cls (push_cls),
    .full     (q_full),
    .pop      (q_pop),
    .pop_vld  (q_vld),
    .pop_cls  (q_cls)
  );

  wwtm_back u_back (
    .clk             (clk),
    .rst_n           (rst_n),
    .line_limit      (line_limit_r),
    .q_vld           (q_vld),
    .q_cls           (q_cls),
    .q_pop           (q_pop),
    .out_valid       (out_valid),
    .out_stall       (out_stall),
    .out_fits        (out_fits),
    .out_width_chars (out_width_chars),
    .out_row_count   (out_row_count),
    .out_char_count  (out_char_count)
  );

endmodule

### bench/word_wrap_text_measurer_test.sv
// testbench for the word wrap text measurer: directed table and random texts
module word_wrap_text_measurer_test;
  import wwtm_pkg::*;

  localparam int SETTLE_CYCLES = 8;
  localparam int HOLD_CYCLES   = 300;
  localparam int CYCLE_LIMIT   = 1_500_000;
  localparam int RANDOM_ITEMS  = 600;
  localparam int RANDOM_TEXTS  = 15;

  typedef struct packed {
    logic             fits;
    logic [CNT_W-1:0] width;
    logic [CNT_W-1:0] rows;
    logic [CNT_W-1:0] chars;
  } box_t;

  typedef enum logic [1:0] {
    ROW_CFG,
    ROW_CODE
  } row_kind_t;

  typedef struct packed {
    row_kind_t       kind;
    logic [CP_W-1:0] value;
    logic            typed;
    box_t            want;
  } row_t;

  logic             clk = 1'b0;
  logic             rst_n = 1'b0;
  logic             cfg_we = 1'b0;
  logic [CNT_W-1:0] cfg_wdata = '0;
  logic             in_valid = 1'b0;
  logic             in_stall;
  logic [CP_W-1:0]  in_code_point = '0;
  logic             out_valid;
  logic             out_stall = 1'b0;
  logic             out_fits;
  logic [CNT_W-1:0] out_width_chars;
  logic [CNT_W-1:0] out_row_count;
  logic [CNT_W-1:0] out_char_count;

  word_wrap_text_measurer dut (
    .clk             (clk),
    .rst_n           (rst_n),
    .cfg_we          (cfg_we),
    .cfg_wdata       (cfg_wdata),
    .in_valid        (in_valid),
    .in_stall        (in_stall),
    .in_code_point   (in_code_point),
    .out_valid       (out_valid),
    .out_stall       (out_stall),
    .out_fits        (out_fits),
    .out_width_chars (out_width_chars),
    .out_row_count   (out_row_count),
    .out_char_count  (out_char_count)
  );

  always #4 clk = ~clk;

  // predictor state
  logic [CNT_W-1:0] lim;
  logic [CNT_W-1:0] ll;
  logic [CNT_W-1:0] longest;
  logic             sp_seen;
  logic [CNT_W-1:0] sp_pos;
  logic [CNT_W-1:0] rows_closed;
  logic [CNT_W-1:0] char_total;
  logic             spilled;

  box_t pending_boxes[$];
  int   errors = 0;
  int   results_seen = 0;
  int   sent = 0;
  int   limits_used = 0;
  int   burst_left = 0;
  bit   steady = 1'b0;
  int   holds_asked = 0;
  int   holds_served = 0;
  int   hold_left = 0;
  int   rx_mode = 0;
  int   rx_mode_left = 0;
  int   rx_tick = 0;
  int   cycle_count;

  row_t plan [31] = '{
    '{ROW_CODE, CODE_END,      1'b1, {1'b1, 16'd0, 16'd1, 16'd0}},
    '{ROW_CODE, 21'd97,        1'b0, '0},
    '{ROW_CODE, 21'h10FFFF,    1'b0, '0},
    '{ROW_CODE, CODE_END,      1'b1, {1'b1, 16'd2, 16'd1, 16'd2}},
    '{ROW_CODE, CODE_SPACE,    1'b0, '0},
    '{ROW_CODE, 21'd98,        1'b0, '0},
    '{ROW_CODE, CODE_SPACE,    1'b0, '0},
    '{ROW_CODE, CODE_SPACE,    1'b0, '0},
    '{ROW_CODE, CODE_NEWLINE,  1'b0, '0},
    '{ROW_CODE, 21'd99,        1'b0, '0},
    '{ROW_CODE, CODE_END,      1'b0, '0},
    '{ROW_CFG,  21'd0,         1'b0, '0},
    '{ROW_CODE, CODE_END,      1'b1, {1'b0, 16'd0, 16'd0, 16'd0}},
    '{ROW_CODE, 21'd120,       1'b0, '0},
    '{ROW_CODE, CODE_END,      1'b1, {1'b0, 16'd0, 16'd0, 16'd1}},
    '{ROW_CFG,  21'd2,         1'b0, '0},
    '{ROW_CODE, 21'd97,        1'b0, '0},
    '{ROW_CODE, 21'd98,        1'b0, '0},
    '{ROW_CODE, CODE_END,      1'b1, {1'b0, 16'd0, 16'd0, 16'd2}},
    '{ROW_CFG,  21'd4,         1'b0, '0},
    '{ROW_CODE, 21'd97,        1'b0, '0},
    '{ROW_CODE, CODE_SPACE,    1'b0, '0},
    '{ROW_CODE, 21'd98,        1'b0, '0},
    '{ROW_CODE, 21'd99,        1'b0, '0},
    '{ROW_CODE, CODE_END,      1'b0, '0},
    '{ROW_CFG,  21'd65535,     1'b0, '0},
    '{ROW_CODE, 21'd122,       1'b0, '0},
    '{ROW_CODE, CODE_END,      1'b1, {1'b1, 16'd1, 16'd1, 16'd1}},
    '{ROW_CFG,  21'd1,         1'b0, '0},
    '{ROW_CODE, 21'd113,       1'b0, '0},
    '{ROW_CODE, CODE_END,      1'b1, {1'b0, 16'd0, 16'd0, 16'd1}}
  };

  function automatic void wipe_text();
    ll          = '0;
    longest     = '0;
    sp_seen     = 1'b0;
    sp_pos      = '0;
    rows_closed = '0;
    char_total  = '0;
    spilled     = 1'b0;
  endfunction

  function automatic void fit_char();
    if (lim == 0 || {1'b0, ll} + 17'd1 >= {1'b0, lim}) begin
      if (!sp_seen) begin
        spilled = 1'b1;
      end else begin
        if (sp_pos > longest) longest = sp_pos;
        if (rows_closed != MAX16) rows_closed = rows_closed + 16'd1;
        ll = (ll >= sp_pos) ? ll - sp_pos : 16'd0;
        sp_seen = 1'b0;
      end
    end else begin
      ll = ll + 16'd1;
    end
  endfunction

  function automatic bit measure_code(input logic [CP_W-1:0] cp, output box_t res);
    res = '0;
    if (cp == CODE_END) begin
      res.fits = !spilled && lim != 0;
      if (res.fits) begin
        res.width = (longest > ll) ? longest : ll;
        res.rows  = (rows_closed == MAX16) ? MAX16 : rows_closed + 16'd1;
      end
      res.chars = char_total;
      wipe_text();
      return 1'b1;
    end
    if (char_total != MAX16) char_total = char_total + 16'd1;
    if (spilled) return 1'b0;
    if (cp == CODE_NEWLINE) begin
      if (ll > longest) longest = ll;
      if (rows_closed != MAX16) rows_closed = rows_closed + 16'd1;
      ll = '0;
      sp_seen = 1'b0;
    end else if (cp == CODE_SPACE) begin
      if (!(sp_seen && sp_pos == ll) && ll != 0) begin
        sp_pos = ll;
        sp_seen = 1'b1;
        fit_char();
      end
    end else begin
      fit_char();
    end
    return 1'b0;
  endfunction

  function automatic void note_failure(input string msg);
    errors++;
    if (errors <= 10) $display("%s", msg);
  endfunction

  task automatic send_code(input logic [CP_W-1:0] cp, input logic typed, input box_t typed_box);
    box_t res;
    int gap;
    if (!steady && burst_left == 0) begin
      burst_left = $urandom_range(1, 24);
      gap = $urandom_range(0, 5);
      if (gap != 0) begin
        in_valid <= 1'b0;
        repeat (gap) @(posedge clk);
      end
    end
    if (burst_left != 0) burst_left--;
    in_valid <= 1'b1;
    in_code_point <= cp;
    @(posedge clk);
    while (in_stall) @(posedge clk);
    if (measure_code(cp, res)) pending_boxes.push_back(typed ? typed_box : res);
    sent++;
  endtask

  task automatic drain();
    in_valid <= 1'b0;
    while (pending_boxes.size() != 0) @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  task automatic set_limit(input logic [CNT_W-1:0] v);
    drain();
    cfg_we <= 1'b1;
    cfg_wdata <= v;
    @(posedge clk);
    cfg_we <= 1'b0;
    lim = v;
    limits_used++;
  endtask

  task automatic send_random_text();
    int words;
    int wlen;
    logic [CP_W-1:0] cp;
    if ($urandom_range(0, 9) == 0) begin
      // noise text
      repeat ($urandom_range(0, 20)) begin
        case ($urandom_range(0, 3))
          0: cp = CODE_SPACE;
          1: cp = CODE_NEWLINE;
          default: cp = 21'($urandom_range(1, 21'h10FFFF));
        endcase
        send_code(cp, 1'b0, '0);
      end
    end else begin
      if ($urandom_range(0, 3) == 0) send_code(CODE_SPACE, 1'b0, '0);
      words = $urandom_range(1, 10);
      for (int w = 0; w < words; w++) begin
        wlen = $urandom_range(1, 9);
        repeat (wlen) begin
          cp = ($urandom_range(0, 7) == 0) ? 21'($urandom_range(1, 21'h10FFFF))
                                            : 21'($urandom_range(97, 122));
          send_code(cp, 1'b0, '0);
        end
        if (w != words - 1 || $urandom_range(0, 4) == 0) begin
          case ($urandom_range(0, 9))
            0: send_code(CODE_NEWLINE, 1'b0, '0);
            1: begin
              send_code(CODE_SPACE, 1'b0, '0);
              send_code(CODE_SPACE, 1'b0, '0);
            end
            2: begin
              send_code(CODE_NEWLINE, 1'b0, '0);
              send_code(CODE_SPACE, 1'b0, '0);
            end
            default: send_code(CODE_SPACE, 1'b0, '0);
          endcase
        end
      end
    end
    send_code(CODE_END, 1'b0, '0);
  endtask

  // receiver stall pattern, with long hold-offs on request
  always @(posedge clk) begin
    rx_tick++;
    if (hold_left != 0) begin
      hold_left--;
      out_stall <= 1'b1;
    end else if (holds_served != holds_asked) begin
      holds_served++;
      hold_left = HOLD_CYCLES;
      out_stall <= 1'b1;
    end else begin
      if (rx_mode_left == 0) begin
        rx_mode = $urandom_range(0, 3);
        rx_mode_left = $urandom_range(10, 80);
      end
      rx_mode_left--;
      case (rx_mode)
        0: out_stall <= 1'b0;
        1: out_stall <= ($urandom_range(0, 9) < 3);
        2: out_stall <= (rx_tick % 4 != 0);
        default: out_stall <= ($urandom_range(0, 9) < 8);
      endcase
    end
  end

  always @(posedge clk) begin : result_check
    box_t want;
    if (rst_n && out_valid && !out_stall) begin
      if (pending_boxes.size() == 0) begin
        note_failure($sformatf("unexpected result fits=%0d width=%0d rows=%0d chars=%0d",
                               out_fits, out_width_chars, out_row_count, out_char_count));
      end else begin
        want = pending_boxes.pop_front();
        if (out_fits !== want.fits || out_width_chars !== want.width ||
            out_row_count !== want.rows || out_char_count !== want.chars)
          note_failure($sformatf({"result %0d: expected fits=%0d width=%0d rows=%0d chars=%0d,",
                                  " got fits=%0d width=%0d rows=%0d chars=%0d"},
                                 results_seen, want.fits, want.width, want.rows, want.chars,
                                 out_fits, out_width_chars, out_row_count, out_char_count));
      end
      results_seen++;
    end
  end

  initial begin
    for (cycle_count = 0; cycle_count < CYCLE_LIMIT; cycle_count++) @(posedge clk);
    $display("TB_ERROR");
    $finish;
  end

  initial begin
    int texts;
    int start_sent;
    logic [CNT_W-1:0] v;
    lim = LIMIT_RESET;
    wipe_text();
    repeat (10) @(posedge clk);
    rst_n <= 1'b1;

    foreach (plan[i]) begin
      if (plan[i].kind == ROW_CFG) set_limit(plan[i].value[CNT_W-1:0]);
      else send_code(plan[i].value, plan[i].typed, plan[i].want);
    end

    // fill the block while the receiver holds off
    set_limit(16'd12);
    steady = 1'b1;
    holds_asked++;
    repeat (40) send_code(CODE_END, 1'b0, '0);
    repeat (3) send_random_text();

    texts = 0;
    start_sent = sent;
    while (sent - start_sent < RANDOM_ITEMS || texts < RANDOM_TEXTS) begin
      if ($urandom_range(0, 5) == 0) begin
        case ($urandom_range(0, 7))
          0: v = 16'd0;
          1: v = 16'hFFFF;
          2: v = 16'($urandom_range(1, 3));
          3: v = 16'($urandom);
          default: v = 16'($urandom_range(4, 24));
        endcase
        set_limit(v);
        steady = ($urandom_range(0, 3) == 0);
      end
      send_random_text();
      texts++;
    end

    drain();
    $display("measured %0d texts from %0d beats under %0d limit settings",
             results_seen, sent, limits_used);
    $display("included zero, tiny and maximum limits, overflowing texts and a long output hold-off");
    if (errors == 0 && pending_boxes.size() == 0) begin
      $display("TB_OK");
    end else begin
      $display("TB_ERROR");
    end
    $finish;
  end

endmodule
